// ----- src/iff_pkg.sv -----
// Shared types and constants for the integer field formatter.
`timescale 1ns / 1ps

package iff_pkg;

	localparam int ARG_W = 32;
	localparam int NDIG = 10;
	localparam int DIG_W = 4;
	localparam int BCD_W = NDIG * DIG_W;
	localparam int CH_W = 8;

	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CH_W-1:0] CH_ZERO = 8'h30;

	// Digit glyphs, entry 0 in the lowest byte.
	localparam logic [15:0][CH_W-1:0] DIGIT_CHARS = "fedcba9876543210";

	typedef logic [DIG_W-1:0] digit_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic measure;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic hex;
		logic last_char;
	} status_t;

endpackage

// ----- src/integer_field_formatter.sv -----
// Top level of the integer field formatter: formats one integer request as a padded ASCII field.
// A request is taken at a rising edge with start high and busy low; it carries the kind
// (func: 0 signed decimal, 1 lowercase hex), the 32-bit value, the field width and the
// precision. Width and precision above MAX_FIELD are taken as MAX_FIELD.
// The field comes out one character per cycle on ch, each marked by valid for exactly one
// cycle, with last set on the final character. The receiver cannot hold characters off.
// A decimal request runs the binary-to-BCD shift loop (ST_CONV), then the layout step
// (ST_MEAS), then emits the characters (ST_EMIT).
// A hex request is loaded straight into the digit register and does no shifting in ST_CONV.
// Busy stays high from acceptance until the last character is registered; a field is
// 1 to MAX_FIELD + 1 characters long.
// The next request may be taken in the cycle the last character is shown.
// Reset is asynchronous and active low; it returns the controller to idle and drops valid.
`timescale 1ns / 1ps

module integer_field_formatter #(
	parameter int MAX_FIELD = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      func,
	input  logic [iff_pkg::ARG_W-1:0] value,
	input  logic [5:0]                width,
	input  logic [5:0]                precision,
	output logic                      valid,
	output logic [iff_pkg::CH_W-1:0]  ch,
	output logic                      last
);

	localparam int CW = $clog2(MAX_FIELD + 2);

	iff_pkg::cmd_t    cmd;
	iff_pkg::status_t status;

	iff_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	iff_dp #(
		.MAX_FIELD (MAX_FIELD),
		.CW        (CW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.func      (func),
		.value     (value),
		.width     (width),
		.precision (precision),
		.status    (status),
		.valid     (valid),
		.ch        (ch),
		.last      (last)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Busy did not rise after an accepted request.");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !busy && !cmd.emit && !cmd.shift)
		else $error("Load issued while a request was in progress.");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid)
		else $error("Character emitted right after the end of a field.");

	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> busy)
		else $error("Character emitted while not busy.");

endmodule

// ----- src/iff_dp.sv -----
// Datapath of the integer field formatter: digit conversion, field layout and character output.
`timescale 1ns / 1ps

module iff_dp #(
	parameter int MAX_FIELD = 48,
	parameter int CW = $clog2(MAX_FIELD + 2)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  iff_pkg::cmd_t                  cmd,
	input  logic                           func,
	input  logic [iff_pkg::ARG_W-1:0]      value,
	input  logic [5:0]                     width,
	input  logic [5:0]                     precision,
	output iff_pkg::status_t               status,
	output logic                           valid,
	output logic [iff_pkg::CH_W-1:0]       ch,
	output logic                           last
);

	logic                                          hex_q;
	logic                                          neg_q;
	logic [CW-1:0]                                 wid_q;
	logic [CW-1:0]                                 prec_q;
	logic [iff_pkg::ARG_W-1:0]                     mag_q;
	logic [iff_pkg::NDIG-1:0][iff_pkg::DIG_W-1:0]  bcd_q;
	logic [CW-1:0]                                 pad_q;
	logic [CW-1:0]                                 sgn_end_q;
	logic [CW-1:0]                                 zero_end_q;
	logic [CW-1:0]                                 last_idx_q;
	logic [CW-1:0]                                 pos_q;
	logic [iff_pkg::CH_W-1:0]                      ch_q;
	logic                                          last_q;
	logic                                          valid_q;

	logic                                          neg_in;
	logic [CW-1:0]                                 wid_c;
	logic [CW-1:0]                                 prec_c;
	logic [iff_pkg::NDIG-1:0][iff_pkg::DIG_W-1:0]  adj_c;
	logic [iff_pkg::BCD_W-1:0]                     adj_flat;
	logic [iff_pkg::BCD_W-1:0]                     bcd_shift;
	logic [iff_pkg::DIG_W-1:0]                     nd_c;
	logic [CW-1:0]                                 nd_w;
	logic [CW-1:0]                                 zeros_c;
	logic [CW-1:0]                                 body_c;
	logic [CW-1:0]                                 total_c;
	logic [CW-1:0]                                 pad_c;
	logic [CW-1:0]                                 sgn_end_c;
	iff_pkg::digit_t                               didx;
	iff_pkg::digit_t                               dsel;
	logic [iff_pkg::CH_W-1:0]                      ch_c;

	assign neg_in = !func && value[iff_pkg::ARG_W-1];
	assign wid_c = (width > 6'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(width);
	assign prec_c = (precision > 6'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(precision);

	// One double-dabble step: correct each decimal digit, then shift in the next bit.
	always_comb begin
		for (int i = 0; i < iff_pkg::NDIG; i++) begin
			adj_c[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end
	assign adj_flat = adj_c;
	assign bcd_shift = {adj_flat[iff_pkg::BCD_W-2:0], mag_q[iff_pkg::ARG_W-1]};

	always_comb begin
		nd_c = 4'd1;
		for (int i = 0; i < iff_pkg::NDIG; i++) begin
			if (bcd_q[i] != '0) begin
				nd_c = 4'(i + 1);
			end
		end
	end

	assign nd_w = CW'(nd_c);
	assign zeros_c = (prec_q > nd_w) ? prec_q - nd_w : '0;
	assign body_c = CW'(neg_q) + zeros_c + nd_w;
	assign total_c = (wid_q > body_c) ? wid_q : body_c;
	assign pad_c = total_c - body_c;
	assign sgn_end_c = pad_c + CW'(neg_q);

	assign didx = iff_pkg::digit_t'(last_idx_q - pos_q);
	assign dsel = bcd_q[didx];

	always_comb begin
		if (pos_q < pad_q) begin
			ch_c = iff_pkg::CH_SPACE;
		end else if (pos_q < sgn_end_q) begin
			ch_c = iff_pkg::CH_MINUS;
		end else if (pos_q < zero_end_q) begin
			ch_c = iff_pkg::CH_ZERO;
		end else begin
			ch_c = iff_pkg::DIGIT_CHARS[dsel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hex_q <= func;
			neg_q <= neg_in;
			wid_q <= wid_c;
			prec_q <= prec_c;
			mag_q <= neg_in ? (~value) + 32'd1 : value;
			if (func) begin
				bcd_q <= iff_pkg::BCD_W'(value);
			end else begin
				bcd_q <= '0;
			end
		end else if (cmd.shift) begin
			bcd_q <= bcd_shift;
			mag_q <= {mag_q[iff_pkg::ARG_W-2:0], 1'b0};
		end
		if (cmd.measure) begin
			pad_q <= pad_c;
			sgn_end_q <= sgn_end_c;
			zero_end_q <= sgn_end_c + zeros_c;
			last_idx_q <= total_c - CW'(1);
			pos_q <= '0;
		end
		if (cmd.emit) begin
			ch_q <= ch_c;
			last_q <= (pos_q == last_idx_q);
			pos_q <= pos_q + CW'(1);
		end
	end

	assign status.hex = hex_q;
	assign status.last_char = (pos_q == last_idx_q);
	assign valid = valid_q;
	assign ch = ch_q;
	assign last = last_q;

endmodule

// ----- src/iff_ctrl.sv -----
// Controller state machine of the integer field formatter.
`timescale 1ns / 1ps

module iff_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  iff_pkg::status_t status,
	output iff_pkg::cmd_t    cmd,
	output logic             busy
);

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_MEAS, ST_EMIT} state_t;

	localparam int BW = $clog2(iff_pkg::ARG_W);

	state_t        state_q;
	logic [BW-1:0] bit_q;
	logic          busy_q;

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.shift = (state_q == ST_CONV) && !status.hex;
		cmd.measure = (state_q == ST_MEAS);
		cmd.emit = (state_q == ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q <= '0;
			busy_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
						bit_q <= '0;
						busy_q <= 1'b1;
					end
				end
				ST_CONV: begin
					if (status.hex) begin
						state_q <= ST_MEAS;
					end else begin
						bit_q <= bit_q + BW'(1);
						if (bit_q == BW'(iff_pkg::ARG_W - 1)) begin
							state_q <= ST_MEAS;
						end
					end
				end
				ST_MEAS: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (status.last_char) begin
						state_q <= ST_IDLE;
						busy_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;

endmodule

// ----- sim/tb_integer_field_formatter.sv -----
// Self-checking testbench for integer_field_formatter: directed and random requests.
`timescale 1ns / 1ps

module tb_integer_field_formatter;

	localparam int FIELD_MAX = 48;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 60;
	localparam logic DEC_KIND = 1'b0;
	localparam logic HEX_KIND = 1'b1;

	typedef struct {
		logic        kind;
		logic [31:0] arg;
		logic [5:0]  fwidth;
		logic [5:0]  fprec;
		int          idle_pct;
		bit          wait_empty;
	} format_req_t;

	typedef struct {
		logic [7:0] code;
		logic       final_char;
	} field_char_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     func;
	logic [iff_pkg::ARG_W-1:0] value;
	logic [5:0]               width;
	logic [5:0]               precision;
	logic                     valid;
	logic [iff_pkg::CH_W-1:0] ch;
	logic                     last;

	format_req_t pending_reqs[$];
	field_char_t expected_chars[$];
	int          mismatches = 0;
	int          cycle_count = 0;

	integer_field_formatter #(.MAX_FIELD(FIELD_MAX)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.value(value),
		.width(width),
		.precision(precision),
		.valid(valid),
		.ch(ch),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] digit_glyph(input logic [3:0] d);
		if (d < 4'd10)
			return 8'h30 + 8'(d);
		return 8'h61 + 8'(d) - 8'd10;
	endfunction

	task automatic push_field_chars(input format_req_t r);
		logic [7:0]  digs[12];
		logic [31:0] mag;
		logic        neg;
		int          nd, wid, prec, zeros, body, pad, i;
		field_char_t c;
		nd = 0;
		wid = (r.fwidth > FIELD_MAX) ? FIELD_MAX : int'(r.fwidth);
		prec = (r.fprec > FIELD_MAX) ? FIELD_MAX : int'(r.fprec);
		neg = (r.kind == DEC_KIND) && r.arg[31];
		mag = neg ? (~r.arg + 32'd1) : r.arg;
		do begin
			if (r.kind == HEX_KIND) begin
				digs[nd] = digit_glyph(mag[3:0]);
				mag = mag >> 4;
			end else begin
				digs[nd] = digit_glyph(4'(mag % 32'd10));
				mag = mag / 32'd10;
			end
			nd++;
		end while (mag != 0 && nd < 11);
		zeros = (prec > nd) ? prec - nd : 0;
		body = (neg ? 1 : 0) + zeros + nd;
		pad = (wid > body) ? wid - body : 0;
		c.final_char = 1'b0;
		c.code = iff_pkg::CH_SPACE;
		for (i = 0; i < pad; i++)
			expected_chars.push_back(c);
		if (neg) begin
			c.code = iff_pkg::CH_MINUS;
			expected_chars.push_back(c);
		end
		c.code = iff_pkg::CH_ZERO;
		for (i = 0; i < zeros; i++)
			expected_chars.push_back(c);
		for (i = nd; i > 0; i--) begin
			c.code = digs[i-1];
			c.final_char = (i == 1);
			expected_chars.push_back(c);
		end
	endtask

	task automatic add_req(input logic k, input logic [31:0] a, input logic [5:0] w,
			input logic [5:0] p, input int idle, input bit hold);
		format_req_t r;
		r.kind = k;
		r.arg = a;
		r.fwidth = w;
		r.fprec = p;
		r.idle_pct = idle;
		r.wait_empty = hold;
		pending_reqs.push_back(r);
	endtask

	function automatic logic [31:0] pick_arg();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'($urandom_range(20));
			2: return 32'h8000_0000 ^ 32'($urandom_range(15));
			3: return {1'b1, 31'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [5:0] pick_size();
		if ($urandom_range(7) == 0)
			return 6'($urandom_range(63));
		return 6'($urandom_range(12));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit go;
		if (!arst_n) begin
			start <= 1'b0;
			func <= DEC_KIND;
			value <= '0;
			width <= '0;
			precision <= '0;
		end else begin
			if (start && !busy) begin
				push_field_chars(pending_reqs[0]);
				void'(pending_reqs.pop_front());
			end
			if (!(start && busy)) begin
				go = 1'b0;
				if (pending_reqs.size() > 0)
					go = ($urandom_range(99) >= pending_reqs[0].idle_pct) &&
						(!pending_reqs[0].wait_empty ||
						(expected_chars.size() == 0 && !busy));
				if (go) begin
					start <= 1'b1;
					func <= pending_reqs[0].kind;
					value <= pending_reqs[0].arg;
					width <= pending_reqs[0].fwidth;
					precision <= pending_reqs[0].fprec;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		field_char_t e;
		if (arst_n && valid) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected character: expected none, actual ch=%h last=%b",
					$time, ch, last);
				mismatches++;
			end else begin
				e = expected_chars.pop_front();
				if (ch !== e.code) begin
					$display("%0t: ch mismatch: expected %h, actual %h", $time, e.code, ch);
					mismatches++;
				end
				if (last !== e.final_char) begin
					$display("%0t: last mismatch: expected %b, actual %b",
						$time, e.final_char, last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("integer_field_formatter test failed");
			$finish;
		end
	end

	initial begin
		int n, idle;
		arst_n = 1'b0;
		add_req(DEC_KIND, 32'd0, 6'd0, 6'd0, 33, 0);
		add_req(HEX_KIND, 32'd0, 6'd0, 6'd0, 33, 0);
		add_req(DEC_KIND, 32'h8000_0000, 6'd0, 6'd0, 33, 0);
		add_req(DEC_KIND, 32'h8000_0000, 6'd63, 6'd63, 33, 0);
		add_req(DEC_KIND, 32'h7fff_ffff, 6'd48, 6'd0, 33, 0);
		add_req(HEX_KIND, 32'hffff_ffff, 6'd0, 6'd0, 33, 0);
		add_req(HEX_KIND, 32'hffff_ffff, 6'd63, 6'd40, 33, 0);
		add_req(DEC_KIND, 32'hffff_ffff, 6'd5, 6'd3, 33, 0);
		add_req(DEC_KIND, 32'hffff_ffff, 6'd63, 6'd63, 33, 0);
		add_req(DEC_KIND, 32'd123, 6'd3, 6'd5, 33, 0);
		add_req(DEC_KIND, 32'd12345, 6'd5, 6'd5, 33, 0);
		add_req(HEX_KIND, 32'h1a, 6'd2, 6'd4, 33, 0);
		add_req(DEC_KIND, 32'd0, 6'd49, 6'd0, 33, 0);
		add_req(DEC_KIND, 32'd0, 6'd0, 6'd48, 33, 0);
		add_req(DEC_KIND, 32'd0, 6'd48, 6'd49, 33, 0);
		add_req(DEC_KIND, 32'hffff_fffb, 6'd1, 6'd0, 33, 0);
		add_req(HEX_KIND, 32'habcd_ef01, 6'd8, 6'd8, 33, 0);
		add_req(DEC_KIND, 32'd1000000000, 6'd10, 6'd10, 33, 0);
		add_req(DEC_KIND, 32'd4000000000, 6'd12, 6'd0, 33, 0);
		add_req(HEX_KIND, 32'h8000_0000, 6'd0, 6'd0, 33, 1);
		add_req(DEC_KIND, 32'h5555_5555, 6'd21, 6'd42, 33, 0);
		add_req(HEX_KIND, 32'h2aaa_aaaa, 6'd42, 6'd21, 33, 0);
		for (n = 0; n < 88; n++) begin
			idle = (n < 25) ? 33 : (n < 65) ? 77 : 0;
			add_req(1'($urandom), pick_arg(), pick_size(), pick_size(), idle,
				(n % 30) == 15);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_reqs.size() != 0 || start)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_chars.size() == 0)
			$display("integer_field_formatter test passed");
		else
			$display("integer_field_formatter test failed");
		$finish;
	end

endmodule
